@@ hw/rtl/vertex_cache_set_assoc_lru_core_macros.svh @@
// Assertion macros for the vertex cache core.
// Used by the port checker; depends on a clock named clk_i and a reset named rst_ni.
`ifndef VERTEX_CACHE_SET_ASSOC_LRU_CORE_MACROS_SVH
`define VERTEX_CACHE_SET_ASSOC_LRU_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCLRU_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vertex cache port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VCLRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vertex cache port check failed");

`endif

@@ hw/rtl/vclru_pkg.sv @@
// Shared constants, types and helpers for the vertex cache core.
// No dependencies; imported by every module of the block except vclru_ram.
`default_nettype none

package vclru_pkg;

  localparam int unsigned SET_COUNT      = 64;
  localparam int unsigned NUM_WAYS       = 4;
  localparam int unsigned VERTS_PER_LINE = 2;
  localparam int unsigned ID_BITS        = 16;

  localparam int unsigned SET_W      = $clog2(SET_COUNT);
  localparam int unsigned VPL_SHIFT  = $clog2(VERTS_PER_LINE);
  localparam int unsigned BLK_W      = ID_BITS - VPL_SHIFT;
  localparam int unsigned FILL_CNT_W = (VERTS_PER_LINE > 1) ? VPL_SHIFT : 1;

  localparam int unsigned CNT_W         = 32;
  localparam int unsigned SAVED_W       = 40;
  localparam int unsigned SAVED_PER_HIT = 120;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FILL,
    ST_DONE
  } vclru_state_e;

  typedef enum logic {
    ROW_TOUCH,
    ROW_FILL
  } vclru_row_op_e;

  typedef enum logic {
    REQ_ACCESS = 1'b0,
    REQ_CLEAR  = 1'b1
  } vclru_req_e;

  typedef struct packed {
    logic clr;
    logic hit_inc;
    logic miss_inc;
  } vclru_stat_cmd_t;

  // Width of a recency rank for a set of the given associativity.
  function automatic int unsigned age_bits(int unsigned ways);
    return (ways > 1) ? $clog2(ways) : 1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vclru_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the set rows of the vertex cache.
`default_nettype none

module vclru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/vclru_row_upd.sv @@
// Combinational update of one set row: tag compare, LRU touch and single-vertex fill.
// Depends on vclru_pkg.
`default_nettype none

module vclru_row_upd import vclru_pkg::*; #(
  parameter int unsigned WAYS = NUM_WAYS
) (
  input  wire vclru_row_op_e                            op_i,
  input  wire logic [ID_BITS-1:0]                       vid_i,
  input  wire logic [WAYS-1:0][ID_BITS-1:0]             vert_i,
  input  wire logic [WAYS-1:0]                          vld_i,
  input  wire logic [WAYS-1:0][age_bits(WAYS)-1:0]      age_i,
  output logic      [WAYS-1:0][ID_BITS-1:0]             vert_o,
  output logic      [WAYS-1:0]                          vld_o,
  output logic      [WAYS-1:0][age_bits(WAYS)-1:0]      age_o,
  output logic                                          hit_o
);

  localparam int unsigned AGE_W = age_bits(WAYS);

  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  free_oh;
  logic [WAYS-1:0]  victim_oh;
  logic [WAYS-1:0]  slot_oh;
  logic [AGE_W-1:0] old_age;
  logic             any_free;

  always_comb begin
    old_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]     = vld_i[w] && (vert_i[w] == vid_i);
      victim_oh[w] = (age_i[w] == AGE_W'(WAYS - 1));
      if (match[w]) begin
        old_age = old_age | age_i[w];
      end
    end
  end

  // First empty way wins; in a full set the ranks form a permutation, so
  // exactly one way carries the oldest rank.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      free_oh[w] = !vld_i[w] && !seen;
      seen       = seen || !vld_i[w];
    end
  end

  assign any_free = |(~vld_i);
  assign slot_oh  = any_free ? free_oh : victim_oh;
  assign hit_o    = |match;

  always_comb begin
    vert_o = vert_i;
    vld_o  = vld_i;
    age_o  = age_i;
    if (op_i == ROW_TOUCH) begin
      if (hit_o) begin
        for (int w = 0; w < WAYS; w++) begin
          if (match[w]) begin
            age_o[w] = '0;
          end else if (vld_i[w] && (age_i[w] < old_age)) begin
            age_o[w] = age_i[w] + AGE_W'(1);
          end
        end
      end
    end else if (!hit_o) begin
      for (int w = 0; w < WAYS; w++) begin
        if (slot_oh[w]) begin
          vert_o[w] = vid_i;
          vld_o[w]  = 1'b1;
          age_o[w]  = '0;
        end else if (vld_i[w]) begin
          age_o[w] = age_i[w] + AGE_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vclru_stats.sv @@
// Saturating hit, miss and saved-operation counters of the vertex cache.
// Depends on vclru_pkg.
`default_nettype none

module vclru_stats import vclru_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vclru_stat_cmd_t      cmd_i,
  output logic      [CNT_W-1:0]     hit_count_o,
  output logic      [CNT_W-1:0]     miss_count_o,
  output logic      [SAVED_W-1:0]   saved_ops_o
);

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SAVED_W-1:0] SAVED_MAX = {SAVED_W{1'b1}};
  localparam logic [SAVED_W-1:0] SAVED_LIM = SAVED_MAX - SAVED_W'(SAVED_PER_HIT);

  logic [CNT_W-1:0]   hits_q,  hits_d;
  logic [CNT_W-1:0]   miss_q,  miss_d;
  logic [SAVED_W-1:0] saved_q, saved_d;

  always_comb begin
    hits_d  = hits_q;
    miss_d  = miss_q;
    saved_d = saved_q;
    if (cmd_i.clr) begin
      hits_d  = '0;
      miss_d  = '0;
      saved_d = '0;
    end else begin
      if (cmd_i.hit_inc) begin
        if (hits_q != CNT_MAX) begin
          hits_d = hits_q + CNT_W'(1);
        end
        saved_d = (saved_q > SAVED_LIM) ? SAVED_MAX : saved_q + SAVED_W'(SAVED_PER_HIT);
      end
      if (cmd_i.miss_inc && (miss_q != CNT_MAX)) begin
        miss_d = miss_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q  <= '0;
      miss_q  <= '0;
      saved_q <= '0;
    end else begin
      hits_q  <= hits_d;
      miss_q  <= miss_d;
      saved_q <= saved_d;
    end
  end

  assign hit_count_o  = hits_q;
  assign miss_count_o = miss_q;
  assign saved_ops_o  = saved_q;

endmodule

`default_nettype wire

@@ hw/rtl/vertex_cache_set_assoc_lru_core.sv @@
// Vertex cache core: 4-way set-associative vertex-ID cache with true LRU.
// Depends on vclru_pkg, vclru_ram, vclru_row_upd and vclru_stats.
//
// Usage. A request beat on the input channel (in_valid_i high, in_stall_o low)
// carries a request type and a vertex id. An access looks the vertex up in its
// set; a miss brings both vertices of its line into the set, evicting the least
// recently used entry of a full set. A clear request empties every set and
// zeroes the counters. Each request produces exactly one result beat on the
// output channel, carrying the hit flag, the block and set index and the
// current saturating hit, miss and saved-operation counters.
// Timing. The set row lives in one RAM with a registered read. An access reads
// the row, then compares and touches it, then writes it back; on a miss a fill
// step for each vertex of the line comes before the write back, since the fills
// go through the same row update unit in turn. A clear neither reads nor writes
// the RAM. The result is loaded into the output register together with the write
// back, if any, and the next request is taken in the cycle after that load.
// Reset clears the per-set valid flags and the counters; the RAM is not cleared.
// A stalled result stays in the output register; one more request may be
// accepted and processed behind it, and its write back waits for the slot.
`default_nettype none

module vertex_cache_set_assoc_lru_core import vclru_pkg::*; #(
  parameter int unsigned WAYS = NUM_WAYS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 req_type_i,
  input  wire logic [ID_BITS-1:0]   vertex_id_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      hit_o,
  output logic      [BLK_W-1:0]     block_index_o,
  output logic      [SET_W-1:0]     set_index_o,
  output logic      [CNT_W-1:0]     hit_count_o,
  output logic      [CNT_W-1:0]     miss_count_o,
  output logic      [SAVED_W-1:0]   saved_ops_o
);

  localparam int unsigned AGE_W = age_bits(WAYS);
  localparam int unsigned ROW_W = WAYS * (ID_BITS + 1 + AGE_W);

  // Control.
  vclru_state_e state_q, state_d;
  logic         in_acc;
  logic         is_clr_req;
  logic         out_free;
  logic         out_load;
  logic         ram_re;
  logic         ram_we;
  logic         row_load;
  logic         fill_last;
  logic [FILL_CNT_W-1:0] fill_cnt_q, fill_cnt_d;
  logic [SET_COUNT-1:0]  set_vld_q, set_vld_d;
  logic         out_valid_q, out_valid_d;
  vclru_stat_cmd_t stat_cmd;

  // Request registers.
  logic [ID_BITS-1:0] vid_q;
  logic               clr_q;
  logic               hit_q;
  logic [BLK_W-1:0]   blk;
  logic [SET_W-1:0]   set_idx;
  logic [SET_W-1:0]   in_set;
  logic [ID_BITS-1:0] fill_vid;

  // Row path.
  logic [ROW_W-1:0]                 ram_rdata;
  logic [ROW_W-1:0]                 ram_wdata;
  logic [WAYS-1:0][ID_BITS-1:0]     rd_vert;
  logic [WAYS-1:0]                  rd_vld;
  logic [WAYS-1:0][AGE_W-1:0]       rd_age;
  logic [WAYS-1:0]                  rd_vld_m;
  logic [WAYS-1:0][ID_BITS-1:0]     row_vert_q;
  logic [WAYS-1:0]                  row_vld_q;
  logic [WAYS-1:0][AGE_W-1:0]       row_age_q;
  vclru_row_op_e                    upd_op;
  logic [ID_BITS-1:0]               upd_vid;
  logic [WAYS-1:0][ID_BITS-1:0]     upd_vert_in, upd_vert_out;
  logic [WAYS-1:0]                  upd_vld_in,  upd_vld_out;
  logic [WAYS-1:0][AGE_W-1:0]       upd_age_in,  upd_age_out;
  logic                             upd_hit;

  // Counters.
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   miss_cnt;
  logic [SAVED_W-1:0] saved_cnt;

  // Output register.
  logic               out_hit_q;
  logic [BLK_W-1:0]   out_blk_q;
  logic [SET_W-1:0]   out_set_q;
  logic [CNT_W-1:0]   out_hits_q;
  logic [CNT_W-1:0]   out_miss_q;
  logic [SAVED_W-1:0] out_saved_q;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_clr_req = (req_type_i == REQ_CLEAR);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fill_last  = (fill_cnt_q == FILL_CNT_W'(VERTS_PER_LINE - 1));

  assign blk     = vid_q[ID_BITS-1:VPL_SHIFT];
  assign set_idx = blk[SET_W-1:0];
  assign in_set  = vertex_id_i[VPL_SHIFT +: SET_W];

  // Vertices of the line are filled in ascending order, one per cycle.
  assign fill_vid = (vid_q & ~ID_BITS'(VERTS_PER_LINE - 1)) | ID_BITS'(fill_cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = is_clr_req ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = upd_hit ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        if (fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o        = 1'b1;
    ram_re            = 1'b0;
    ram_we            = 1'b0;
    row_load          = 1'b0;
    out_load          = 1'b0;
    fill_cnt_d        = fill_cnt_q;
    stat_cmd.clr      = 1'b0;
    stat_cmd.hit_inc  = 1'b0;
    stat_cmd.miss_inc = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        ram_re       = in_valid_i && !is_clr_req;
        stat_cmd.clr = in_valid_i && is_clr_req;
      end
      ST_LOOK: begin
        row_load          = 1'b1;
        fill_cnt_d        = '0;
        stat_cmd.hit_inc  = upd_hit;
        stat_cmd.miss_inc = !upd_hit;
      end
      ST_FILL: begin
        row_load   = 1'b1;
        fill_cnt_d = fill_cnt_q + FILL_CNT_W'(1);
      end
      ST_DONE: begin
        out_load = out_free;
        ram_we   = out_free && !clr_q;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_cnt_q  <= '0;
      set_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_cnt_q  <= fill_cnt_d;
      set_vld_q   <= set_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // One valid flag per set row; a row whose flag is low reads as empty, so a
  // clear only resets the flags and writes no RAM row.
  always_comb begin
    set_vld_d = set_vld_q;
    if (stat_cmd.clr) begin
      set_vld_d = '0;
    end
    if (ram_we) begin
      set_vld_d[set_idx] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vid_q <= vertex_id_i;
      clr_q <= is_clr_req;
    end
    if (state_q == ST_LOOK) begin
      hit_q <= upd_hit;
    end
  end

  // Set row storage.
  assign ram_wdata = {row_age_q, row_vld_q, row_vert_q};

  vclru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  assign {rd_age, rd_vld, rd_vert} = ram_rdata;
  assign rd_vld_m = set_vld_q[set_idx] ? rd_vld : '0;

  // The lookup cycle works on the fresh RAM word; fill cycles work on the
  // row register so each vertex sees the previous one's placement.
  always_comb begin
    if (state_q == ST_FILL) begin
      upd_op      = ROW_FILL;
      upd_vid     = fill_vid;
      upd_vert_in = row_vert_q;
      upd_vld_in  = row_vld_q;
      upd_age_in  = row_age_q;
    end else begin
      upd_op      = ROW_TOUCH;
      upd_vid     = vid_q;
      upd_vert_in = rd_vert;
      upd_vld_in  = rd_vld_m;
      upd_age_in  = rd_age;
    end
  end

  vclru_row_upd #(
    .WAYS (WAYS)
  ) u_row_upd (
    .op_i   (upd_op),
    .vid_i  (upd_vid),
    .vert_i (upd_vert_in),
    .vld_i  (upd_vld_in),
    .age_i  (upd_age_in),
    .vert_o (upd_vert_out),
    .vld_o  (upd_vld_out),
    .age_o  (upd_age_out),
    .hit_o  (upd_hit)
  );

  // On a lookup miss the touch leaves the row as read, so the update output
  // can be loaded unconditionally.
  always_ff @(posedge clk_i) begin
    if (row_load) begin
      row_vert_q <= upd_vert_out;
      row_vld_q  <= upd_vld_out;
      row_age_q  <= upd_age_out;
    end
  end

  vclru_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (stat_cmd),
    .hit_count_o  (hit_cnt),
    .miss_count_o (miss_cnt),
    .saved_ops_o  (saved_cnt)
  );

  // Result register. A clear reports zero indexes and no hit.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= hit_q && !clr_q;
      out_blk_q   <= clr_q ? '0 : blk;
      out_set_q   <= clr_q ? '0 : set_idx;
      out_hits_q  <= hit_cnt;
      out_miss_q  <= miss_cnt;
      out_saved_q <= saved_cnt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign block_index_o = out_blk_q;
  assign set_index_o   = out_set_q;
  assign hit_count_o   = out_hits_q;
  assign miss_count_o  = out_miss_q;
  assign saved_ops_o   = out_saved_q;

endmodule

`default_nettype wire

@@ hw/rtl/vclru_checker.sv @@
// Port-level checker for the vertex cache core, bound to the top level.
// Depends on vclru_pkg and vertex_cache_set_assoc_lru_core_macros.svh.
`default_nettype none

`include "vertex_cache_set_assoc_lru_core_macros.svh"

module vclru_checker import vclru_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               hit_o,
  input wire logic [BLK_W-1:0]   block_index_o,
  input wire logic [SET_W-1:0]   set_index_o,
  input wire logic [CNT_W-1:0]   hit_count_o,
  input wire logic [SAVED_W-1:0] saved_ops_o
);

  // A held result beat keeps its payload.
  `VCLRU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(block_index_o) && $stable(hit_count_o) && $stable(saved_ops_o))

  // The set index is the low part of the block index.
  `VCLRU_ASSERT(a_set_of_block, out_valid_o, set_index_o == block_index_o[SET_W-1:0])

  // Until the hit counter saturates, saved operations track it exactly.
  `VCLRU_ASSERT(a_saved_tracks, out_valid_o && (hit_count_o != {CNT_W{1'b1}}), saved_ops_o == SAVED_W'(hit_count_o) * SAVED_W'(SAVED_PER_HIT))

  // A hit result always carries a nonzero hit count.
  `VCLRU_ASSERT(a_hit_counted, out_valid_o && hit_o, hit_count_o != '0)

  // Requests are processed one at a time: an accepted beat closes the input.
  `VCLRU_ASSERT_NXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind vertex_cache_set_assoc_lru_core vclru_checker u_vclru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hit_o         (hit_o),
  .block_index_o (block_index_o),
  .set_index_o   (set_index_o),
  .hit_count_o   (hit_count_o),
  .saved_ops_o   (saved_ops_o)
);

`default_nettype wire

@@ sim/vertex_cache_set_assoc_lru_core_test.sv @@
// Self-checking testbench for vertex_cache_set_assoc_lru_core, the 4-way LRU vertex-ID cache.
// Depends on vclru_pkg and the core RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module vertex_cache_set_assoc_lru_core_test;
  import vclru_pkg::*;

  // Everything the core reports for one request.
  typedef struct {
    logic               hit;
    logic [BLK_W-1:0]   block;
    logic [SET_W-1:0]   set_no;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [SAVED_W-1:0] saved;
  } lookup_result_t;

  // The scoreboard keeps its own copy of the cache tags, valid flags, recency ranks and
  // counters. note_request updates that copy when a request beat is accepted and queues
  // the result the core must report; check_result compares a result beat with the oldest
  // queued one.
  class vertex_lru_scoreboard;
    logic [ID_BITS-1:0] way_vid [SET_COUNT][NUM_WAYS];
    bit                 way_vld [SET_COUNT][NUM_WAYS];
    int unsigned        way_rank[SET_COUNT][NUM_WAYS];
    logic [CNT_W-1:0]   hit_sum;
    logic [CNT_W-1:0]   miss_sum;
    logic [SAVED_W-1:0] saved_sum;
    lookup_result_t     expected_q[$];
    int unsigned        errors;
    int unsigned        n_hits, n_misses, n_clears, n_checked;

    function new();
      foreach (way_vld[s, w]) way_vld[s][w] = 1'b0;
      hit_sum   = '0;
      miss_sum  = '0;
      saved_sum = '0;
      errors    = 0;
      n_hits    = 0;
      n_misses  = 0;
      n_clears  = 0;
      n_checked = 0;
    endfunction

    function int lookup_way(int unsigned set_no, logic [ID_BITS-1:0] vid);
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_vld[set_no][w] && way_vid[set_no][w] == vid) return w;
      end
      return -1;
    endfunction

    // Hit: every valid way more recent than the touched one ages by one.
    function void make_recent(int unsigned set_no, int way);
      int unsigned old_rank;
      old_rank = way_rank[set_no][way];
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_vld[set_no][w] && way_rank[set_no][w] < old_rank) way_rank[set_no][w]++;
      end
      way_rank[set_no][way] = 0;
    endfunction

    // Miss fill of one vertex. A vertex already in the set is left alone, recency too.
    // Otherwise the first free way is taken, or the least recent one of a full set.
    function void fill_vertex(int unsigned set_no, logic [ID_BITS-1:0] vid);
      int slot;
      slot = -1;
      if (lookup_way(set_no, vid) >= 0) return;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!way_vld[set_no][w]) begin
          slot = w;
          break;
        end
      end
      if (slot < 0) begin
        slot = 0;
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (way_rank[set_no][w] > way_rank[set_no][slot]) slot = w;
        end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_vld[set_no][w] && w != slot) way_rank[set_no][w]++;
      end
      way_vid[set_no][slot]  = vid;
      way_vld[set_no][slot]  = 1'b1;
      way_rank[set_no][slot] = 0;
    endfunction

    function void note_request(vclru_req_e rtype, logic [ID_BITS-1:0] vid);
      lookup_result_t exp;
      int unsigned    blk, set_no, first_vid;
      int             way;
      exp.hit    = 1'b0;
      exp.block  = '0;
      exp.set_no = '0;
      if (rtype == REQ_CLEAR) begin
        foreach (way_vld[s, w]) way_vld[s][w] = 1'b0;
        hit_sum   = '0;
        miss_sum  = '0;
        saved_sum = '0;
        n_clears++;
      end else begin
        blk        = vid / VERTS_PER_LINE;
        set_no     = blk % SET_COUNT;
        exp.block  = blk[BLK_W-1:0];
        exp.set_no = set_no[SET_W-1:0];
        way        = lookup_way(set_no, vid);
        if (way >= 0) begin
          exp.hit = 1'b1;
          make_recent(set_no, way);
          if (hit_sum != '1) hit_sum++;
          // The saved-operations total sticks at its top value instead of wrapping.
          if (saved_sum > {SAVED_W{1'b1}} - SAVED_PER_HIT) saved_sum = '1;
          else saved_sum = saved_sum + SAVED_PER_HIT;
          n_hits++;
        end else begin
          if (miss_sum != '1) miss_sum++;
          first_vid = blk * VERTS_PER_LINE;
          for (int i = 0; i < VERTS_PER_LINE; i++) begin
            fill_vertex(set_no, ID_BITS'(first_vid + i));
          end
          n_misses++;
        end
      end
      exp.hits   = hit_sum;
      exp.misses = miss_sum;
      exp.saved  = saved_sum;
      expected_q.insert(expected_q.size(), exp);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding: hit %0d block %0d set %0d",
               got.hit, got.block, got.set_no);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      n_checked++;
      if (got.hit !== exp.hit) begin
        $error("hit expected %0d got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.block !== exp.block) begin
        $error("block_index expected %0d got %0d", exp.block, got.block);
        errors++;
      end
      if (got.set_no !== exp.set_no) begin
        $error("set_index expected %0d got %0d", exp.set_no, got.set_no);
        errors++;
      end
      if (got.hits !== exp.hits) begin
        $error("hit_count expected %0d got %0d", exp.hits, got.hits);
        errors++;
      end
      if (got.misses !== exp.misses) begin
        $error("miss_count expected %0d got %0d", exp.misses, got.misses);
        errors++;
      end
      if (got.saved !== exp.saved) begin
        $error("saved_ops expected %0d got %0d", exp.saved, got.saved);
        errors++;
      end
    endfunction
  endclass

  // All inputs start at known values; reset is held from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               req_type_i  = REQ_ACCESS;
  logic [ID_BITS-1:0] vertex_id_i = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               hit_o;
  logic [BLK_W-1:0]   block_index_o;
  logic [SET_W-1:0]   set_index_o;
  logic [CNT_W-1:0]   hit_count_o;
  logic [CNT_W-1:0]   miss_count_o;
  logic [SAVED_W-1:0] saved_ops_o;

  vertex_lru_scoreboard lru_model;

  // Idle rates in percent, changed between phases of the run.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Recently requested vertices, reused by the random part to produce hits.
  logic [ID_BITS-1:0] recent_vids[$];

  vertex_cache_set_assoc_lru_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .vertex_id_i  (vertex_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .block_index_o(block_index_o),
    .set_index_o  (set_index_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o),
    .saved_ops_o  (saved_ops_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sends one request beat. Idle cycles, if any, come before the beat is offered, so
  // valid never reacts to stall. Once offered, the payload holds until the core takes it.
  // Signals are sampled right after the edge, so they show the values the core saw.
  task automatic send_request(vclru_req_e rtype, logic [ID_BITS-1:0] vid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rtype;
    vertex_id_i <= vid;
    do @(posedge clk_i); while (in_stall_o);
    lru_model.note_request(rtype, vid);
  endtask

  task automatic send_access(logic [ID_BITS-1:0] vid);
    send_request(REQ_ACCESS, vid);
  endtask

  // Random request mix. Most accesses hit a few hot sets with eight lines each, which
  // keeps those four-way sets full and evicting; about a quarter reuse a recent vertex
  // to make hits likely. The rest are vertices anywhere in the id space, so every bit
  // of the id toggles, plus an occasional clear with a random (ignored) id.
  task automatic send_random_request();
    int unsigned        pick, line, set_no;
    logic [ID_BITS-1:0] vid;
    vclru_req_e         rtype;
    pick  = $urandom_range(99);
    rtype = REQ_ACCESS;
    vid   = ID_BITS'($urandom);
    if (pick < 1) begin
      rtype = REQ_CLEAR;
    end else if (pick < 61) begin
      set_no = $urandom_range(3) * 17;
      line   = $urandom_range(7) * SET_COUNT + set_no;
      vid    = ID_BITS'(line * VERTS_PER_LINE + $urandom_range(VERTS_PER_LINE - 1));
    end else if (pick < 86 && recent_vids.size() != 0) begin
      vid = recent_vids[$urandom_range(recent_vids.size() - 1)];
    end
    if (rtype == REQ_ACCESS) begin
      recent_vids.insert(recent_vids.size(), vid);
      if (recent_vids.size() > 8) void'(recent_vids.pop_front());
    end
    send_request(rtype, vid);
  endtask

  // Result side: the stall for the next edge is chosen after each edge; a beat counts
  // when valid is high and stall was low at that edge.
  initial begin
    lookup_result_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.hit    = hit_o;
        got.block  = block_index_o;
        got.set_no = set_index_o;
        got.hits   = hit_count_o;
        got.misses = miss_count_o;
        got.saved  = saved_ops_o;
        lru_model.check_result(got);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog. It ends a run that has not finished in time as a failure.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    lru_model = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Start with a clear on an empty cache, then the lowest and highest
    // vertex ids, with a hit on the partner vertex each brought in.
    send_request(REQ_CLEAR, '1);
    send_access('0);
    send_access(16'd1);
    send_access('1);
    send_access(16'hFFFE);
    // Fill set 0 with lines 0 and 64, touch vertex 0, then bring in line 128. Its two
    // vertices evict vertex 1 and then vertex 128, the least recent entries.
    send_access(16'd128);
    send_access(16'd0);
    send_access(16'd256);
    // Vertex 1 misses while its partner 0 is still present: the fill skips vertex 0
    // without changing its recency and evicts only for vertex 1.
    send_access(16'd1);
    send_access(16'd0);
    send_access(16'd129);
    send_access(16'd257);
    // Back-to-back requests to the same set, then alternating patterns in the id bits.
    send_access(16'd384);
    send_access(16'd385);
    send_access(16'h5555);
    send_access(16'hAAAA);
    send_access(16'hAAAB);
    send_access(16'h5554);
    // A clear with a nonzero id, then proof that the old contents are gone.
    send_request(REQ_CLEAR, 16'h1234);
    send_access(16'hAAAA);
    send_access(16'hAAAB);
    send_access(16'd0);

    // Random part in three idle patterns, about 1750 requests in all.
    send_idle_pct  = 25;
    recv_stall_pct = 57;
    repeat (584) send_random_request();
    send_idle_pct  = 57;
    recv_stall_pct = 25;
    repeat (583) send_random_request();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (583) send_random_request();
    in_valid_i <= 1'b0;

    // Drain, then watch a while longer for stray result beats.
    while (lru_model.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d result beats: %0d hits, %0d misses, %0d clears.",
             lru_model.n_checked, lru_model.n_hits, lru_model.n_misses, lru_model.n_clears);
    $display("Idle patterns covered: sender-light, receiver-light, and back-to-back.");
    if (lru_model.errors == 0 && lru_model.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
